[hdl/link_frame_receiver_checker_core_defines.svh]
// assertion macros for the link frame receiver checker
`ifndef LINK_FRAME_RECEIVER_CHECKER_CORE_DEFINES_SVH
`define LINK_FRAME_RECEIVER_CHECKER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// property holds at every clock edge outside reset
`define LFRC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define LFRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define LFRC_ASSERT(lbl, clk, rst_n, prop, msg)
`define LFRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[hdl/lfrc_pkg.sv]
// shared constants for the link frame receiver checker
`default_nettype none

package lfrc_pkg;

  localparam int unsigned CountBitsDefault = 12;
  localparam int unsigned DataCountBits    = 12;
  localparam int unsigned CfgIndexBits     = 2;
  localparam int unsigned ErrBits          = 5;

  localparam logic [7:0] FlagByte = 8'h7E;

  localparam logic [7:0] ExpAddressReset = 8'h01;
  localparam logic [7:0] ExpControlReset = 8'h07;
  localparam logic       HasDataReset    = 1'b0;

  localparam logic [CfgIndexBits-1:0] CfgExpAddress = 2'd0;
  localparam logic [CfgIndexBits-1:0] CfgExpControl = 2'd1;
  localparam logic [CfgIndexBits-1:0] CfgHasData    = 2'd2;

  localparam logic [2:0] PosFlag    = 3'd0;
  localparam logic [2:0] PosAddress = 3'd1;
  localparam logic [2:0] PosControl = 3'd2;
  localparam logic [2:0] PosHeader  = 3'd3;
  localparam logic [2:0] PosData    = 3'd4;

  localparam int unsigned ErrFlag   = 0;
  localparam int unsigned ErrAddr   = 1;
  localparam int unsigned ErrCtrl   = 2;
  localparam int unsigned ErrHeader = 3;
  localparam int unsigned ErrData   = 4;

  localparam logic RkData   = 1'b0;
  localparam logic RkStatus = 1'b1;

endpackage

`default_nettype wire

[hdl/link_frame_receiver_checker_core.sv]
// link frame receiver and checker, byte in, data byte or frame status out
//
// channel | direction | handshake            | payload
// in      | in        | in_valid_i/in_stall_o | rx_byte_i
// out     | out       | out_valid_o/out_stall_i | result_kind_o, data_byte_o, error bits,
//         |           |                      | data_count_o
// cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one byte accepted per cycle while in_stall_o is low, result registered in the cycle after the byte that causes it
// input compare, xor and count logic sits between the byte and the result register
// in_stall_o is high only while a result waits and the downstream stalls
// async active-low reset returns the parser to waiting for the opening flag
// cfg writes are taken every cycle
`default_nettype none

module link_frame_receiver_checker_core #(
  parameter int unsigned COUNT_BITS = lfrc_pkg::CountBitsDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [7:0]                        rx_byte_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic                                   result_kind_o,
  output logic [7:0]                             data_byte_o,
  output logic                                   flag_error_o,
  output logic                                   address_error_o,
  output logic                                   control_error_o,
  output logic                                   header_check_error_o,
  output logic                                   data_check_error_o,
  output logic [lfrc_pkg::DataCountBits-1:0]     data_count_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [lfrc_pkg::CfgIndexBits-1:0] cfg_index_i,
  input  wire logic [7:0]                        cfg_data_i
);
  import lfrc_pkg::*;

  `include "link_frame_receiver_checker_core_defines.svh"

  localparam int unsigned WideBits = (COUNT_BITS > DataCountBits) ? COUNT_BITS : DataCountBits;
  localparam logic [COUNT_BITS-1:0]    CountMax    = {COUNT_BITS{1'b1}};
  localparam logic [DataCountBits-1:0] DataCntMax  = {DataCountBits{1'b1}};

  logic [7:0] exp_addr_q, exp_ctrl_q;
  logic       has_data_q;

  logic [2:0]            pos_q, pos_d;
  logic [7:0]            got_addr_q, got_addr_d;
  logic [7:0]            got_ctrl_q, got_ctrl_d;
  logic [7:0]            held_q, held_d;
  logic                  held_valid_q, held_valid_d;
  logic [7:0]            xor_q, xor_d;
  logic [ErrBits-1:0]    err_q, err_d;
  logic [COUNT_BITS-1:0] count_q, count_d;

  logic                     out_valid_q;
  logic                     kind_q, kind_d;
  logic [7:0]               dbyte_q, dbyte_d;
  logic [ErrBits-1:0]       oerr_q, oerr_d;
  logic [DataCountBits-1:0] ocount_q, ocount_d;

  logic                     in_fire, emit;
  logic [WideBits-1:0]      count_wide;
  logic [DataCountBits-1:0] count_sat;
  logic [7:0]               check;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_fire     = in_valid_i && !in_stall_o;

  assign count_wide = WideBits'(count_q);
  assign count_sat  = (count_wide > WideBits'(DataCntMax)) ? DataCntMax
                                                           : count_wide[DataCountBits-1:0];
  assign check      = held_valid_q ? held_q : 8'h00;

  always_comb begin
    pos_d        = pos_q;
    got_addr_d   = got_addr_q;
    got_ctrl_d   = got_ctrl_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    xor_d        = xor_q;
    err_d        = err_q;
    count_d      = count_q;
    emit         = 1'b0;
    kind_d       = RkData;
    dbyte_d      = 8'h00;
    case (pos_q)
      PosFlag: begin
        err_d          = '0;
        err_d[ErrFlag] = (rx_byte_i != FlagByte);
        got_addr_d     = 8'h00;
        got_ctrl_d     = 8'h00;
        held_d         = 8'h00;
        held_valid_d   = 1'b0;
        xor_d          = 8'h00;
        count_d        = '0;
        pos_d          = PosAddress;
      end
      PosAddress: begin
        got_addr_d = rx_byte_i;
        if (rx_byte_i != exp_addr_q) err_d[ErrAddr] = 1'b1;
        pos_d = PosControl;
      end
      PosControl: begin
        got_ctrl_d = rx_byte_i;
        if (rx_byte_i != exp_ctrl_q) err_d[ErrCtrl] = 1'b1;
        pos_d = PosHeader;
      end
      PosHeader: begin
        if (rx_byte_i != (got_addr_q ^ got_ctrl_q)) err_d[ErrHeader] = 1'b1;
        pos_d = PosData;
      end
      PosData: begin
        if (!has_data_q) begin
          if (rx_byte_i != FlagByte) err_d[ErrFlag] = 1'b1;
          emit   = 1'b1;
          kind_d = RkStatus;
          pos_d  = PosFlag;
        end else if (rx_byte_i == FlagByte) begin
          if (check != xor_q) err_d[ErrData] = 1'b1;
          emit   = 1'b1;
          kind_d = RkStatus;
          pos_d  = PosFlag;
        end else if (held_valid_q) begin
          xor_d = xor_q ^ held_q;
          if (count_q != CountMax) count_d = count_q + 1'b1;
          held_d  = rx_byte_i;
          emit    = 1'b1;
          dbyte_d = held_q;
        end else begin
          held_d       = rx_byte_i;
          held_valid_d = 1'b1;
        end
      end
      default: begin
        pos_d = PosFlag;
      end
    endcase
  end

  always_comb begin
    oerr_d   = '0;
    ocount_d = '0;
    if (kind_d == RkStatus) begin
      oerr_d   = err_d;
      ocount_d = count_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_addr_q <= ExpAddressReset;
      exp_ctrl_q <= ExpControlReset;
      has_data_q <= HasDataReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgExpAddress: exp_addr_q <= cfg_data_i;
        CfgExpControl: exp_ctrl_q <= cfg_data_i;
        CfgHasData:    has_data_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= PosFlag;
      got_addr_q   <= 8'h00;
      got_ctrl_q   <= 8'h00;
      held_q       <= 8'h00;
      held_valid_q <= 1'b0;
      xor_q        <= 8'h00;
      err_q        <= '0;
      count_q      <= '0;
    end else if (in_fire) begin
      pos_q        <= pos_d;
      got_addr_q   <= got_addr_d;
      got_ctrl_q   <= got_ctrl_d;
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      xor_q        <= xor_d;
      err_q        <= err_d;
      count_q      <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, loaded on each emitting transfer
  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      kind_q   <= kind_d;
      dbyte_q  <= dbyte_d;
      oerr_q   <= oerr_d;
      ocount_q <= ocount_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign result_kind_o        = kind_q;
  assign data_byte_o          = dbyte_q;
  assign flag_error_o         = oerr_q[ErrFlag];
  assign address_error_o      = oerr_q[ErrAddr];
  assign control_error_o      = oerr_q[ErrCtrl];
  assign header_check_error_o = oerr_q[ErrHeader];
  assign data_check_error_o   = oerr_q[ErrData];
  assign data_count_o         = ocount_q;

  `LFRC_ASSERT(a_data_result_clean, clk_i, rst_ni,
               !(out_valid_o && result_kind_o == RkData) || (oerr_q == '0 && data_count_o == '0),
               "data result carries status bits")
  `LFRC_ASSERT(a_status_no_byte, clk_i, rst_ni,
               !(out_valid_o && result_kind_o == RkStatus) || (data_byte_o == 8'h00),
               "status result carries a data byte")
  `LFRC_ASSERT(a_held_in_data, clk_i, rst_ni,
               !held_valid_q || (pos_q == PosData) || (pos_q == PosFlag),
               "held byte outside data field")
  `LFRC_ASSERT_NEXT(a_status_restarts, clk_i, rst_ni,
                    in_fire && emit && kind_d == RkStatus,
                    pos_q == PosFlag && out_valid_q && result_kind_o == RkStatus,
                    "status did not return parser to flag wait")
  `LFRC_ASSERT_NEXT(a_super_close, clk_i, rst_ni,
                    in_fire && pos_q == PosData && !has_data_q,
                    out_valid_q && result_kind_o == RkStatus,
                    "supervisory frame closed without status")

endmodule

`default_nettype wire

[tb/sv/frame_status_monitor.sv]
`timescale 1ns / 100ps
// frame status monitor: predicts the frame checker's results from transfers and compares them
module frame_status_monitor (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic [7:0]                         rx_byte_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic                               result_kind_i,
  input  logic [7:0]                         data_byte_i,
  input  logic                               flag_error_i,
  input  logic                               address_error_i,
  input  logic                               control_error_i,
  input  logic                               header_check_error_i,
  input  logic                               data_check_error_i,
  input  logic [lfrc_pkg::DataCountBits-1:0] data_count_i,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [lfrc_pkg::CfgIndexBits-1:0]  cfg_index_i,
  input  logic [7:0]                         cfg_data_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);
  import lfrc_pkg::*;

  typedef struct packed {
    logic                     kind;
    logic [7:0]               data;
    logic [ErrBits-1:0]       errs;
    logic [DataCountBits-1:0] count;
  } frame_result_t;

  logic [7:0]                  want_address;
  logic [7:0]                  want_control;
  logic                        info_frames;
  logic [2:0]                  position;
  logic [7:0]                  seen_address;
  logic [7:0]                  seen_control;
  logic [7:0]                  held_byte;
  logic                        held_valid;
  logic [7:0]                  data_xor;
  logic [ErrBits-1:0]          errs;
  logic [CountBitsDefault-1:0] data_bytes;
  frame_result_t               awaited_results[$];
  int                          mismatches = 0;

  function automatic frame_result_t frame_status();
    frame_result_t r;
    r = '0;
    r.kind = RkStatus;
    r.errs = errs;
    r.count = data_bytes;
    position = PosFlag;
    return r;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, output frame_result_t r);
    bit produced;
    produced = 1'b0;
    r = '0;
    case (position)
      PosFlag: begin
        errs = '0;
        errs[ErrFlag] = (b != FlagByte);
        seen_address = '0;
        seen_control = '0;
        held_byte = '0;
        held_valid = 1'b0;
        data_xor = '0;
        data_bytes = '0;
        position = PosAddress;
      end
      PosAddress: begin
        seen_address = b;
        if (b != want_address) errs[ErrAddr] = 1'b1;
        position = PosControl;
      end
      PosControl: begin
        seen_control = b;
        if (b != want_control) errs[ErrCtrl] = 1'b1;
        position = PosHeader;
      end
      PosHeader: begin
        if (b != (seen_address ^ seen_control)) errs[ErrHeader] = 1'b1;
        position = PosData;
      end
      PosData: begin
        produced = 1'b1;
        if (!info_frames) begin
          if (b != FlagByte) errs[ErrFlag] = 1'b1;
          r = frame_status();
        end else if (b == FlagByte) begin
          if ((held_valid ? held_byte : 8'h00) != data_xor) errs[ErrData] = 1'b1;
          r = frame_status();
        end else if (held_valid) begin
          r.kind = RkData;
          r.data = held_byte;
          data_xor = data_xor ^ held_byte;
          if (data_bytes != '1) data_bytes = data_bytes + 1'b1;
          held_byte = b;
        end else begin
          held_byte = b;
          held_valid = 1'b1;
          produced = 1'b0;
        end
      end
      default: position = PosFlag;
    endcase
    return produced;
  endfunction

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t got;
    frame_result_t want;
    frame_result_t predicted;
    if (!rst_ni) begin
      want_address = ExpAddressReset;
      want_control = ExpControlReset;
      info_frames = HasDataReset;
      position = PosFlag;
      seen_address = '0;
      seen_control = '0;
      held_byte = '0;
      held_valid = 1'b0;
      data_xor = '0;
      errs = '0;
      data_bytes = '0;
      awaited_results.delete();
      pending_o <= 0;
      fail_count_o <= mismatches;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got.kind = result_kind_i;
        got.data = data_byte_i;
        got.errs[ErrFlag] = flag_error_i;
        got.errs[ErrAddr] = address_error_i;
        got.errs[ErrCtrl] = control_error_i;
        got.errs[ErrHeader] = header_check_error_i;
        got.errs[ErrData] = data_check_error_i;
        got.count = data_count_i;
        if (awaited_results.size() == 0) begin
          $display("%0t: result expected none, got kind %0h data %0h errors %0h count %0h",
                   $time, got.kind, got.data, got.errs, got.count);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("result_kind", 32'(want.kind), 32'(got.kind));
          check_field("data_byte", 32'(want.data), 32'(got.data));
          check_field("flag_error", 32'(want.errs[ErrFlag]), 32'(got.errs[ErrFlag]));
          check_field("address_error", 32'(want.errs[ErrAddr]), 32'(got.errs[ErrAddr]));
          check_field("control_error", 32'(want.errs[ErrCtrl]), 32'(got.errs[ErrCtrl]));
          check_field("header_check_error", 32'(want.errs[ErrHeader]),
                      32'(got.errs[ErrHeader]));
          check_field("data_check_error", 32'(want.errs[ErrData]), 32'(got.errs[ErrData]));
          check_field("data_count", 32'(want.count), 32'(got.count));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (parse_byte(rx_byte_i, predicted)) awaited_results.push_back(predicted);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgExpAddress: want_address = cfg_data_i;
          CfgExpControl: want_control = cfg_data_i;
          CfgHasData:    info_frames = cfg_data_i[0];
          default: ;
        endcase
      end
      pending_o <= awaited_results.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// testbench top for the link frame receiver checker: byte and register stimulus, verdict
module tb;
  import lfrc_pkg::*;

  localparam logic [CfgIndexBits-1:0] CfgUnused = 2'd3;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned RandomBytes = 950;
  localparam logic [7:0] ControlCodes [5] = '{8'h07, 8'h05, 8'h85, 8'h00, 8'h40};

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [7:0]              rx_byte = 8'h00;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    result_kind;
  logic [7:0]              data_byte;
  logic                    flag_error;
  logic                    address_error;
  logic                    control_error;
  logic                    header_check_error;
  logic                    data_check_error;
  logic [DataCountBits-1:0] data_count;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CfgIndexBits-1:0] cfg_index = '0;
  logic [7:0]              cfg_data = 8'h00;
  int                      fails;
  int                      pending;
  int unsigned             cycle_count = 0;
  int unsigned             bytes_sent = 0;
  bit                      quiet = 1'b0;

  always #1 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  link_frame_receiver_checker_core i_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .rx_byte_i           (rx_byte),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .result_kind_o       (result_kind),
    .data_byte_o         (data_byte),
    .flag_error_o        (flag_error),
    .address_error_o     (address_error),
    .control_error_o     (control_error),
    .header_check_error_o(header_check_error),
    .data_check_error_o  (data_check_error),
    .data_count_o        (data_count),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data)
  );

  frame_status_monitor i_monitor (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .rx_byte_i           (rx_byte),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .result_kind_i       (result_kind),
    .data_byte_i         (data_byte),
    .flag_error_i        (flag_error),
    .address_error_i     (address_error),
    .control_error_i     (control_error),
    .header_check_error_i(header_check_error),
    .data_check_error_i  (data_check_error),
    .data_count_i        (data_count),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_i         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .fail_count_o        (fails),
    .pending_o           (pending)
  );

  function automatic int pick_gap();
    int roll;
    if (quiet) return 0;
    roll = int'($urandom_range(0, 99));
    if (roll < 55) return 0;
    if (roll < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 30));
  endfunction

  function automatic logic [7:0] any_but_flag();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == FlagByte) b = ~b;
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_seq(input logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic cfg_write(input logic [CfgIndexBits-1:0] idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(input logic [7:0] addr, input logic [7:0] ctrl, input logic hd);
    logic [7:0] hd_word;
    hd_word = 8'($urandom);
    hd_word[0] = hd;
    cfg_write(CfgUnused, 8'($urandom));
    cfg_write(CfgExpAddress, addr);
    cfg_write(CfgExpControl, ctrl);
    cfg_write(CfgHasData, hd_word);
    cfg_valid <= 1'b0;
  endtask

  // wait for every pending result, then let the parser settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
  endtask

  task automatic send_frame(input logic hd, input logic [7:0] addr, input logic [7:0] ctrl);
    logic [7:0] a;
    logic [7:0] c;
    logic [7:0] x;
    logic [7:0] b;
    int n;
    a = ($urandom_range(0, 9) == 0) ? 8'($urandom) : addr;
    c = ($urandom_range(0, 9) == 0) ? 8'($urandom) : ctrl;
    send_byte(($urandom_range(0, 19) == 0) ? 8'($urandom) : FlagByte);
    send_byte(a);
    send_byte(c);
    send_byte(($urandom_range(0, 9) == 0) ? 8'($urandom) : a ^ c);
    if (hd) begin
      n = ($urandom_range(0, 15) == 0) ? int'($urandom_range(20, 60))
                                       : int'($urandom_range(0, 10));
      x = 8'h00;
      repeat (n) begin
        b = ($urandom_range(0, 39) == 0) ? FlagByte : any_but_flag();
        x = x ^ b;
        send_byte(b);
      end
      if (x == FlagByte) begin
        send_byte(8'h01);
        x = x ^ 8'h01;
      end
      if (n > 0 || $urandom_range(0, 1) == 1)
        send_byte(($urandom_range(0, 9) == 0) ? any_but_flag() : x);
      send_byte(FlagByte);
    end else begin
      send_byte(($urandom_range(0, 9) == 0) ? 8'($urandom) : FlagByte);
    end
  endtask

  // receiver back-pressure
  initial begin
    int n;
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("link_frame_receiver_checker_core regression: fail");
    $finish;
  end

  initial begin
    int unsigned goal;
    int roll;
    logic [7:0] addr;
    logic [7:0] ctrl;
    logic hd;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset values, then every error bit but the data check with a bad closing flag
    send_seq('{FlagByte, 8'h01, 8'h07, 8'h06, FlagByte});
    send_seq('{8'h00, 8'hFF, 8'hF8, 8'h00, 8'h00});
    drain();

    // information frames: empty, and a wrong data check
    program_regs(8'hFF, 8'h00, 1'b1);
    send_seq('{FlagByte, 8'hFF, 8'h00, 8'hFF, FlagByte});
    send_seq('{FlagByte, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, FlagByte});
    drain();

    // registers changed part way through a frame
    program_regs(8'h00, 8'h40, 1'b1);
    send_seq('{FlagByte, 8'h00, 8'h40, 8'h40, 8'hA5, 8'h5A});
    drain();
    program_regs(8'h00, 8'h40, 1'b0);
    send_byte(8'h3C);
    drain();

    // data count saturation
    quiet = 1'b1;
    program_regs(8'h01, 8'h00, 1'b1);
    send_seq('{FlagByte, 8'h01, 8'h00, 8'h01});
    repeat (4100) send_byte(any_but_flag());
    send_byte(FlagByte);
    drain();

    goal = bytes_sent + RandomBytes;
    while (bytes_sent < goal) begin
      quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0:       addr = 8'h00;
        1:       addr = 8'hFF;
        default: addr = 8'($urandom);
      endcase
      roll = int'($urandom_range(0, 7));
      if (roll < 5) ctrl = ControlCodes[roll];
      else if (roll == 5) ctrl = 8'hFF;
      else ctrl = 8'($urandom);
      hd = 1'($urandom_range(0, 1));
      drain();
      program_regs(addr, ctrl, hd);
      repeat ($urandom_range(2, 8)) begin
        if ($urandom_range(0, 4) == 0) send_noise();
        else send_frame(hd, addr, ctrl);
      end
    end
    drain();

    if (fails == 0 && pending == 0) begin
      $display("link_frame_receiver_checker_core regression: pass");
    end else begin
      $display("link_frame_receiver_checker_core regression: fail");
    end
    $finish;
  end

endmodule
